[design/tqs_pkg.sv]
// Package: shared types and constants of the timer queue scheduler.
`default_nettype none
package tqs_pkg;
  localparam int unsigned TimeW = 63;
  localparam int unsigned IdW = 4;
  localparam int unsigned AgeW = 8;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    FuncAdd  = 2'd0,
    FuncDel  = 2'd1,
    FuncTick = 2'd2,
    FuncNop  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatFull     = 2'd1,
    StatNotFound = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [IdW-1:0]   timer_id;
    logic [TimeW-1:0] deadline;
    logic [TimeW-1:0] period;
    logic [TimeW-1:0] now_time;
  } in_t;

  typedef struct packed {
    logic             fired_valid;
    logic [IdW-1:0]   fired_id;
    logic [1:0]       status;
    logic             next_valid;
    logic [TimeW-1:0] next_deadline;
    logic             last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic apply;     // perform add or delete
    logic scan_clr;  // start a selection scan
    logic scan_step; // examine one slot
    logic fire;      // fire selected slot
    logic min_clr;   // start earliest scan
    logic min_step;  // examine one slot for earliest
    logic out_load;  // build result from current state
    logic out_next;  // advance result read pointer
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic found;
    logic grp;
    logic min_done;
    logic out_last;
  } sts_t;
endpackage
`default_nettype wire

[design/tqs_if.sv]
// Interface: valid/ready channel carrying one payload beat.
`default_nettype none
interface tqs_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/tqs_dp.sv]
// Datapath: timer slot storage, sequential selection scan, fired list, earliest-deadline scan and result build.
`default_nettype none
module tqs_dp #(
  parameter int unsigned TimerSlots = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tqs_pkg::in_t  in_i,
  input  wire tqs_pkg::cmd_t cmd_i,
  output tqs_pkg::sts_t      sts_o,
  output tqs_pkg::out_t      out_o
);
  import tqs_pkg::*;
  localparam int unsigned SW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int unsigned CW = $clog2(TimerSlots + 1);
  localparam int unsigned MaxRes = 16;
  localparam int unsigned RW = $clog2(MaxRes + 1);

  logic [TimerSlots-1:0] used_q, due_q;
  logic [TimeW-1:0] dl_q [TimerSlots];
  logic [TimeW-1:0] per_q [TimerSlots];
  logic [AgeW-1:0] age_q [TimerSlots];
  logic [AgeW-1:0] agec_q;
  logic [AgeW-1:0] abase_q;
  in_t in_q;
  logic [1:0] status_q;
  logic [CW-1:0] scan_q;
  logic grp_q, found_q;
  logic [SW-1:0] best_q;
  logic [TimeW-1:0] bdl_q;
  logic [AgeW-1:0] bage_q;
  logic [IdW-1:0] ord_q [MaxRes];
  logic [RW-1:0] n_q, rd_q;
  logic [TimeW-1:0] min_q;
  logic any_q;

  logic [SW-1:0] si;
  logic id_ok;
  logic [SW-1:0] id_s;
  logic cand, better;
  logic [AgeW-1:0] ra, rb;
  logic [TimeW:0] sum;

  assign si = scan_q[SW-1:0];
  assign id_ok = (32'(in_q.timer_id) < TimerSlots);
  assign id_s = SW'(in_q.timer_id);
  // tie order is relative to the age counter at the start of the tick
  assign ra = age_q[si] - abase_q;
  assign rb = bage_q - abase_q;
  assign cand = due_q[si] && ((per_q[si] != '0) == grp_q);
  assign better = !found_q || (dl_q[si] < bdl_q) || (dl_q[si] == bdl_q && ra < rb);
  assign sum = {1'b0, dl_q[best_q]} + {1'b0, per_q[best_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      due_q <= '0;
      agec_q <= '0;
      abase_q <= '0;
      scan_q <= '0;
      grp_q <= 1'b0;
      found_q <= 1'b0;
      n_q <= '0;
      rd_q <= '0;
    end else begin
      if (cmd_i.load) begin
        n_q <= '0;
        grp_q <= 1'b0;
        scan_q <= '0;
        abase_q <= agec_q;
        status_q <= StatOk;
        for (int i = 0; i < TimerSlots; i++) begin
          due_q[i] <= used_q[i] && dl_q[i] <= in_i.now_time;
        end
      end
      if (cmd_i.apply) begin
        if (in_q.func == FuncAdd) begin
          if (!id_ok || used_q[id_s]) begin
            status_q <= StatFull;
          end else begin
            used_q[id_s] <= 1'b1;
            dl_q[id_s] <= in_q.deadline;
            per_q[id_s] <= in_q.period;
            age_q[id_s] <= agec_q;
            agec_q <= agec_q + 1'b1;
          end
        end else if (in_q.func == FuncDel) begin
          if (id_ok && used_q[id_s] && per_q[id_s] != '0) begin
            used_q[id_s] <= 1'b0;
          end else begin
            status_q <= StatNotFound;
          end
        end
      end
      if (cmd_i.scan_clr || cmd_i.min_clr) begin
        scan_q <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + 1'b1;
        if (cand && better) begin
          found_q <= 1'b1;
          best_q <= si;
          bdl_q <= dl_q[si];
          bage_q <= age_q[si];
        end
      end
      if (cmd_i.scan_clr && !cmd_i.fire && found_q == 1'b0 && scan_q == CW'(TimerSlots)) begin
        grp_q <= 1'b1;
      end
      if (cmd_i.fire) begin
        due_q[best_q] <= 1'b0;
        if (n_q < RW'(MaxRes)) begin
          ord_q[n_q[RW-2:0]] <= IdW'(best_q);
          n_q <= n_q + 1'b1;
        end
        if (per_q[best_q] == '0) begin
          used_q[best_q] <= 1'b0;
        end else begin
          dl_q[best_q] <= sum[TimeW] ? TimeMax : sum[TimeW-1:0];
          age_q[best_q] <= agec_q;
          agec_q <= agec_q + 1'b1;
        end
      end
      if (cmd_i.min_clr) begin
        min_q <= TimeMax;
        any_q <= 1'b0;
      end
      if (cmd_i.min_step) begin
        scan_q <= scan_q + 1'b1;
        if (used_q[si]) begin
          any_q <= 1'b1;
          if (!any_q || dl_q[si] < min_q) min_q <= dl_q[si];
        end
      end
      if (cmd_i.out_load) rd_q <= '0;
      if (cmd_i.out_next) rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_i;
  end

  assign sts_o.is_tick = (in_q.func == FuncTick);
  assign sts_o.scan_done = (scan_q == CW'(TimerSlots));
  assign sts_o.found = found_q;
  assign sts_o.grp = grp_q;
  assign sts_o.min_done = (scan_q == CW'(TimerSlots));
  assign sts_o.out_last = (n_q == '0) || (rd_q + 1'b1 >= n_q);

  always_comb begin
    out_o.fired_valid = (n_q != '0);
    out_o.fired_id = (n_q != '0) ? ord_q[rd_q[RW-2:0]] : '0;
    out_o.status = status_q;
    out_o.next_valid = any_q;
    out_o.next_deadline = any_q ? min_q : '0;
    out_o.last = sts_o.out_last;
  end
endmodule
`default_nettype wire

[design/tqs_ctrl.sv]
// Controller: state machine sequencing load, update, fire scans, earliest scan and output beats.
`default_nettype none
module tqs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire tqs_pkg::sts_t sts_i,
  output tqs_pkg::cmd_t      cmd_o
);
  import tqs_pkg::*;
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StApply = 6'b000010,
    StScan  = 6'b000100,
    StFire  = 6'b001000,
    StMin   = 6'b010000,
    StOut   = 6'b100000
  } state_e;
  state_e state_q, state_d;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StApply;
        end
      end
      StApply: begin
        cmd_o.apply = 1'b1;
        if (sts_i.is_tick) begin
          cmd_o.scan_clr = 1'b1;
          state_d = StScan;
        end else begin
          cmd_o.min_clr = 1'b1;
          state_d = StMin;
        end
      end
      StScan: begin
        if (!sts_i.scan_done) begin
          cmd_o.scan_step = 1'b1;
        end else if (sts_i.found) begin
          state_d = StFire;
        end else if (!sts_i.grp) begin
          cmd_o.scan_clr = 1'b1;
        end else begin
          cmd_o.min_clr = 1'b1;
          state_d = StMin;
        end
      end
      StFire: begin
        cmd_o.fire = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d = StScan;
      end
      StMin: begin
        if (!sts_i.min_done) begin
          cmd_o.min_step = 1'b1;
        end else begin
          cmd_o.out_load = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.out_last) state_d = StIdle;
          else cmd_o.out_next = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

[design/timer_queue_scheduler.sv]
// Top level: timer queue scheduler with one-shot and periodic timers.
// Add, delete and no-op go from the accepting edge through an update step and a
// scan over all slots for the earliest deadline to the output beat. A tick runs
// one selection scan over all slots per fired timer plus one fire step each, one
// empty scan closing each of the two groups (one-shot first, then periodic),
// then the earliest scan, before its first beat; one beat per fired timer (at
// least one) follows. One item is in work at a time; the single shared slot
// scan sets the rate.
`default_nettype none
module timer_queue_scheduler #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tqs_if.sink      in_i,
  tqs_if.source    out_o
);
  import tqs_pkg::*;
  cmd_t cmd;
  sts_t sts;

  tqs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tqs_dp #(.TimerSlots(TIMER_SLOTS)) u_dp (
    .clk_i, .rst_ni,
    .in_i (in_i.data),
    .cmd_i(cmd),
    .sts_o(sts),
    .out_o(out_o.data)
  );

  a_no_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("input and output overlap");
  a_fire_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fire |=> !cmd.fire) else $error("back-to-back fire");
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.data.last |=> in_i.ready)
    else $error("not idle after last beat");
endmodule
`default_nettype wire

[tb/timer_queue_scheduler_tb.sv]
// Testbench: timer queue scheduler checked beat by beat against a behavioral predictor.
`timescale 1ns / 100ps
`default_nettype none
module timer_queue_scheduler_tb;
  import tqs_pkg::*;

  localparam int unsigned Slots = 16;
  localparam int unsigned CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tqs_if #(.T(in_t)) in_ch ();
  tqs_if #(.T(out_t)) out_ch ();

  timer_queue_scheduler #(.TIMER_SLOTS(Slots)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_ch.sink),
    .out_o(out_ch.source)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic             armed [Slots];
  logic [TimeW-1:0] due_at [Slots];
  logic [TimeW-1:0] every [Slots];
  logic [AgeW-1:0]  stamp [Slots];
  logic [AgeW-1:0]  stamp_next;

  in_t  pending_beats [$];
  out_t expected_beats [$];
  int   errors = 0;
  int   beats_seen = 0;
  int   fired_seen = 0;
  int   cycles = 0;
  bit   feeding_done = 1'b0;
  bit   hold_sink = 1'b0;
  int   sink_hold_cycles = 0;

  function automatic bit orders_first(int a, int b);
    logic [AgeW-1:0] ra, rb;
    if (due_at[a] != due_at[b]) return due_at[a] < due_at[b];
    ra = stamp[a] - stamp_next;
    rb = stamp[b] - stamp_next;
    return ra < rb;
  endfunction

  task automatic enqueue_beat(input in_t b);
    pending_beats = {pending_beats, b};
  endtask

  task automatic predict_timers(input in_t b);
    int order [$];
    bit pick [Slots];
    int best;
    bit found;
    logic [1:0] stat;
    logic [TimeW:0] sum;
    logic any;
    logic [TimeW-1:0] early;
    out_t r;
    stat = StatOk;
    order = {};
    case (func_e'(b.func))
      FuncAdd: begin
        if (armed[b.timer_id]) stat = StatFull;
        else begin
          armed[b.timer_id] = 1'b1;
          due_at[b.timer_id] = b.deadline;
          every[b.timer_id] = b.period;
          stamp[b.timer_id] = stamp_next;
          stamp_next++;
        end
      end
      FuncDel: begin
        if (armed[b.timer_id] && every[b.timer_id] != 0) armed[b.timer_id] = 1'b0;
        else stat = StatNotFound;
      end
      FuncTick: begin
        for (int i = 0; i < Slots; i++) pick[i] = armed[i] && due_at[i] <= b.now_time;
        for (int g = 0; g < 2; g++) begin
          forever begin
            found = 1'b0;
            best = 0;
            for (int i = 0; i < Slots; i++)
              if (pick[i] && ((every[i] != 0) == g) && (!found || orders_first(i, best))) begin
                best = i;
                found = 1'b1;
              end
            if (!found) break;
            pick[best] = 1'b0;
            order = {order, best};
          end
        end
        foreach (order[k]) begin
          if (every[order[k]] == 0) armed[order[k]] = 1'b0;
          else begin
            sum = {1'b0, due_at[order[k]]} + {1'b0, every[order[k]]};
            due_at[order[k]] = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
            stamp[order[k]] = stamp_next;
            stamp_next++;
          end
        end
      end
      default: ;
    endcase
    any = 1'b0;
    early = TimeMax;
    for (int i = 0; i < Slots; i++)
      if (armed[i] && (!any || due_at[i] < early)) begin
        early = due_at[i];
        any = 1'b1;
      end
    if (order.size() == 0) order = {-1};
    foreach (order[k]) begin
      r.fired_valid = order[k] >= 0;
      r.fired_id = order[k] >= 0 ? IdW'(order[k]) : '0;
      r.status = stat;
      r.next_valid = any;
      r.next_deadline = any ? early : '0;
      r.last = k == order.size() - 1;
      expected_beats = {expected_beats, r};
    end
  endtask

  function automatic logic [TimeW-1:0] rand_time();
    case ($urandom_range(0, 9))
      0: return TimeMax;
      1: return TimeMax - $urandom_range(0, 3);
      2: return TimeW'({$urandom, $urandom});
      default: return TimeW'($urandom_range(0, 400));
    endcase
  endfunction

  function automatic in_t mk(func_e f, int id, logic [TimeW-1:0] dl, logic [TimeW-1:0] per,
                             logic [TimeW-1:0] now);
    in_t b;
    b.func = f;
    b.timer_id = IdW'(id);
    b.deadline = dl;
    b.period = per;
    b.now_time = now;
    return b;
  endfunction

  // driver
  int src_gap = 0;
  in_t cur;
  bit in_took = 1'b0;
  bit in_wait = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      in_wait = in_ch.valid && !in_took;
      if (in_took) begin
        in_took = 1'b0;
        src_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) src_gap = 0;
      end
      if (in_wait) begin
      end else if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_beats.size() > 0 && pending_beats[0].func === 2'bxx) begin
        // pause marker: drain before continuing
        in_ch.valid <= 1'b0;
        if (expected_beats.size() == 0) void'(pending_beats.pop_front());
      end else if (pending_beats.size() > 0) begin
        cur = pending_beats.pop_front();
        in_ch.data <= cur;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
        if (!in_ch.valid) feeding_done = 1'b1;
      end
    end
  end

  // sink stalls
  int snk_gap = 0;
  always @(negedge clk_i) begin
    if (sink_hold_cycles > 0) begin
      sink_hold_cycles--;
      out_ch.ready <= 1'b0;
    end else if (hold_sink) begin
      hold_sink = 1'b0;
      sink_hold_cycles = 3000;
      out_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0)
        snk_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
    end
  end

  // monitor
  out_t exp_b;
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (out_ch.data.fired_valid) fired_seen++;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, out_ch.data);
      end else begin
        exp_b = expected_beats.pop_front();
        if (out_ch.data !== exp_b) begin
          errors++;
          $display("%0t: mismatch expected fv=%0d id=%0d st=%0d nv=%0d nd=%0d last=%0d",
                   $time, exp_b.fired_valid, exp_b.fired_id, exp_b.status, exp_b.next_valid,
                   exp_b.next_deadline, exp_b.last);
          $display("%0t:          actual   fv=%0d id=%0d st=%0d nv=%0d nd=%0d last=%0d",
                   $time, out_ch.data.fired_valid, out_ch.data.fired_id, out_ch.data.status,
                   out_ch.data.next_valid, out_ch.data.next_deadline, out_ch.data.last);
        end
      end
    end
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predict_timers(in_ch.data);
      in_took = 1'b1;
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  in_t pause_mark;
  int live_ids [$];
  logic [TimeW-1:0] clock_now;
  int nrand;
  initial begin
    pause_mark = 'x;
    for (int i = 0; i < Slots; i++) begin
      armed[i] = 1'b0;
      due_at[i] = '0;
      every[i] = '0;
      stamp[i] = '0;
    end
    stamp_next = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;

    // directed
    enqueue_beat(mk(FuncTick, 0, '0, '0, TimeMax));
    enqueue_beat(mk(FuncDel, 3, '0, '0, '0));
    enqueue_beat(mk(FuncAdd, 0, 5, 0, 0));
    enqueue_beat(mk(FuncAdd, 0, 9, 0, 0));
    enqueue_beat(mk(FuncDel, 0, '0, '0, '0));
    enqueue_beat(mk(FuncAdd, 15, 5, 7, 0));
    enqueue_beat(mk(FuncAdd, 7, 5, 3, 0));
    enqueue_beat(mk(FuncAdd, 2, 5, 0, 0));
    enqueue_beat(mk(FuncAdd, 9, TimeMax - 1, TimeMax, 0));
    enqueue_beat(mk(FuncAdd, 4, TimeMax, 1, 0));
    enqueue_beat(mk(FuncNop, 1, '1, '1, '1));
    enqueue_beat(mk(FuncTick, 0, '0, '0, 4));
    enqueue_beat(mk(FuncTick, 0, '0, '0, 12));
    enqueue_beat(pause_mark);
    enqueue_beat(mk(FuncTick, 0, '0, '0, TimeMax));
    enqueue_beat(mk(FuncDel, 15, '0, '0, '0));
    enqueue_beat(mk(FuncDel, 7, '0, '0, '0));
    enqueue_beat(mk(FuncDel, 9, '0, '0, '0));
    enqueue_beat(mk(FuncDel, 4, '0, '0, '0));
    enqueue_beat(mk(FuncTick, 0, '0, '0, '1));

    // random: adds and ticks with advancing time, mixed with deletes and arbitrary beats
    clock_now = 0;
    nrand = 0;
    while (nrand < 140) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: enqueue_beat(mk(FuncAdd, $urandom_range(0, 15),
            clock_now + $urandom_range(0, 200), ($urandom_range(0, 2) == 0) ? 0 :
            (($urandom_range(0, 15) == 0) ? rand_time() : $urandom_range(1, 150)), rand_time()));
        4: enqueue_beat(mk(FuncDel, $urandom_range(0, 15), rand_time(),
            rand_time(), rand_time()));
        5: enqueue_beat(mk(func_e'($urandom_range(0, 3)), $urandom_range(0, 15),
            rand_time(), rand_time(), rand_time()));
        default: begin
          clock_now += $urandom_range(0, 120);
          enqueue_beat(mk(FuncTick, $urandom_range(0, 15), rand_time(), rand_time(),
              ($urandom_range(0, 30) == 0) ? TimeMax : clock_now));
        end
      endcase
      nrand++;
      if (nrand == 70) enqueue_beat(pause_mark);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_sink = 1'b1;

    wait (feeding_done);
    wait (expected_beats.size() == 0);
    repeat (2000) @(posedge clk_i);
    $display("covered %0d result beats, %0d fired timers, one-shot/periodic/full/not-found",
             beats_seen, fired_seen);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[timer_queue_scheduler.f]
design/tqs_pkg.sv
design/tqs_if.sv
design/tqs_dp.sv
design/tqs_ctrl.sv
design/timer_queue_scheduler.sv
tb/timer_queue_scheduler_tb.sv
